[sv/pts_pkg.sv]
// Package for the process table scheduler.
// Holds the event, action and policy codes and the controller/datapath command and status types.
// No dependencies.
package pts_pkg;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_TERM  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_BEGIN = 2'd3;

	localparam logic [1:0] POL_NONE = 2'd0;
	localparam logic [1:0] POL_RR   = 2'd1;
	localparam logic [1:0] POL_FCFS = 2'd2;
	localparam logic [1:0] POL_SJF  = 2'd3;

	localparam logic [2:0] ACT_START    = 3'd0;
	localparam logic [2:0] ACT_STOP     = 3'd1;
	localparam logic [2:0] ACT_TERM_OK  = 3'd2;
	localparam logic [2:0] ACT_UNKNOWN  = 3'd3;
	localparam logic [2:0] ACT_ALL_DONE = 3'd4;
	localparam logic [2:0] ACT_FULL     = 3'd5;

	typedef enum logic [1:0] {
		RD_IDX    = 2'd0,
		RD_IDX_P1 = 2'd1,
		RD_BEST   = 2'd2,
		RD_PTR    = 2'd3
	} rd_sel_t;

	typedef enum logic [1:0] {
		REF_TID  = 2'd0,
		REF_RD   = 2'd1,
		REF_ZERO = 2'd2
	} ref_sel_t;

	typedef struct packed {
		logic       capture;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_append;
		logic       wr_compact;
		logic       flag_set_best;
		logic       idx_clr;
		logic       idx_inc;
		logic       best_clr;
		logic       best_from_ptr;
		logic       scan_upd;
		logic       remove;
		logic       ptr_clr;
		logic       ptr_wrap;
		logic       ptr_adv;
		logic       jr_clr;
		logic       emit;
		logic [2:0] emit_act;
		ref_sel_t   emit_ref;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic count_one;
		logic match;
		logic idx_last;
		logic flag_best;
		logic jr;
		logic out_free;
	} status_t;

endpackage

[sv/pts_if.sv]
// Handshake channel interfaces for the process table scheduler.
// Event channel and result channel; no dependencies.
interface pts_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] task_id;
	logic [31:0] expected_time;

	modport source (output valid, output mode, output task_id, output expected_time,
		input ready);
	modport sink (input valid, input mode, input task_id, input expected_time,
		output ready);
endinterface

interface pts_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [31:0] task_ref;
	logic        last;

	modport source (output valid, output action, output task_ref, output last,
		input ready);
	modport sink (input valid, input action, input task_ref, input last,
		output ready);
endinterface

[sv/pts_dp.sv]
// Datapath of the process table scheduler: task tables, flags, pointers and result register.
// Driven by commands from pts_ctrl; depends on pts_pkg.
module pts_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pts_pkg::cmd_t      cmd,
	output pts_pkg::status_t   st,
	input  logic [31:0]        in_task_id,
	input  logic [31:0]        in_expected_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_action,
	output logic [31:0]        out_task_ref,
	output logic               out_last
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [31:0]            id_mem [TABLE_DEPTH];
	logic [31:0]            time_mem [TABLE_DEPTH];
	logic [31:0]            id_rd_q;
	logic [31:0]            time_rd_q;
	logic [TABLE_DEPTH-1:0] flags_q;
	logic [CW-1:0]          count_q;
	logic [IW-1:0]          ptr_q;
	logic                   jr_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          best_q;
	logic [31:0]            best_time_q;
	logic [31:0]            tid_q;
	logic [31:0]            etime_q;
	logic                   out_valid_q;
	logic [2:0]             out_action_q;
	logic [31:0]            out_ref_q;
	logic                   out_last_q;

	logic [IW-1:0] idx_p1;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] app_addr;
	logic [CW-1:0] count_m1;
	logic          ptr_at_end;

	assign idx_p1     = idx_q + IW'(1);
	assign app_addr   = IW'(count_q);
	assign count_m1   = count_q - CW'(1);
	assign ptr_at_end = CW'(ptr_q) >= count_m1;

	always_comb begin
		case (cmd.rd_sel)
			pts_pkg::RD_IDX:    rd_addr = idx_q;
			pts_pkg::RD_IDX_P1: rd_addr = idx_p1;
			pts_pkg::RD_BEST:   rd_addr = best_q;
			pts_pkg::RD_PTR:    rd_addr = ptr_q;
			default:            rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_append) begin
			id_mem[app_addr]   <= tid_q;
			time_mem[app_addr] <= etime_q;
		end else if (cmd.wr_compact) begin
			id_mem[idx_q]   <= id_rd_q;
			time_mem[idx_q] <= time_rd_q;
		end
		if (cmd.rd_en) begin
			id_rd_q   <= id_mem[rd_addr];
			time_rd_q <= time_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tid_q   <= in_task_id;
			etime_q <= in_expected_time;
		end
		if (cmd.best_clr) begin
			best_q <= '0;
		end else if (cmd.best_from_ptr) begin
			best_q <= ptr_q;
		end else if (cmd.scan_upd && (idx_q == '0 || time_rd_q < best_time_q)) begin
			best_q      <= idx_q;
			best_time_q <= time_rd_q;
		end
		if (cmd.emit) begin
			out_action_q <= cmd.emit_act;
			out_last_q   <= cmd.emit_last;
			case (cmd.emit_ref)
				pts_pkg::REF_TID:  out_ref_q <= tid_q;
				pts_pkg::REF_RD:   out_ref_q <= id_rd_q;
				pts_pkg::REF_ZERO: out_ref_q <= '0;
				default:           out_ref_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			jr_q        <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_append) begin
				flags_q[app_addr] <= 1'b0;
				count_q           <= count_q + CW'(1);
			end else if (cmd.wr_compact) begin
				flags_q[idx_q] <= flags_q[idx_p1];
			end else if (cmd.flag_set_best) begin
				flags_q[best_q] <= 1'b1;
			end

			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end

			if (cmd.remove) begin
				count_q <= count_m1;
				jr_q    <= 1'b1;
				if (CW'(ptr_q) >= count_m1) begin
					ptr_q <= (count_m1 == '0) ? '0 : IW'(count_m1 - CW'(1));
				end
			end else if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_wrap) begin
				if (ptr_at_end) begin
					ptr_q <= '0;
				end
			end else if (cmd.ptr_adv) begin
				ptr_q <= ptr_at_end ? '0 : ptr_q + IW'(1);
			end
			if (cmd.jr_clr) begin
				jr_q <= 1'b0;
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.full      = count_q == CW'(TABLE_DEPTH);
		st.empty     = count_q == '0;
		st.count_one = count_q == CW'(1);
		st.match     = id_rd_q == tid_q;
		st.idx_last  = (CW'(idx_q) + CW'(1)) >= count_q;
		st.flag_best = flags_q[best_q];
		st.jr        = jr_q;
		st.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign out_action   = out_action_q;
	assign out_task_ref = out_ref_q;
	assign out_last     = out_last_q;

endmodule

[sv/pts_ctrl.sv]
// Controller state machine of the process table scheduler, with the policy register.
// Issues commands to pts_dp and reads its status; depends on pts_pkg.
module pts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             evt_valid,
	output logic             evt_ready,
	input  logic [1:0]       evt_mode,
	input  pts_pkg::status_t st,
	output pts_pkg::cmd_t    cmd
);

	typedef enum logic [21:0] {
		S_IDLE        = 22'h000001,
		S_ADD_WR      = 22'h000002,
		S_EMIT_FULL   = 22'h000004,
		S_EMIT_UNK    = 22'h000008,
		S_EMIT_DONE   = 22'h000010,
		S_EMIT_TERM   = 22'h000020,
		S_SRCH_RD     = 22'h000040,
		S_SRCH_CMP    = 22'h000080,
		S_COMP        = 22'h000100,
		S_COMP_WR     = 22'h000200,
		S_REMOVE      = 22'h000400,
		S_SEL_INIT    = 22'h000800,
		S_SCAN_RD     = 22'h001000,
		S_SCAN_CMP    = 22'h002000,
		S_SEL_DONE    = 22'h004000,
		S_START_RD    = 22'h008000,
		S_START_EMIT  = 22'h010000,
		S_TICK_JR     = 22'h020000,
		S_TICK_STOP_RD = 22'h040000,
		S_TICK_STOP_EM = 22'h080000,
		S_TICK_LOAD   = 22'h100000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	state_t     follow_q;
	state_t     follow_d;
	logic       term_q;
	logic       term_d;
	logic [1:0] policy_q;

	assign evt_ready = state_q == S_IDLE;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		follow_d = follow_q;
		term_d   = term_q;
		case (state_q)
			S_IDLE: begin
				if (evt_valid) begin
					cmd.capture = 1'b1;
					case (evt_mode)
						pts_pkg::MODE_ADD: begin
							state_d = st.full ? S_EMIT_FULL : S_ADD_WR;
						end
						pts_pkg::MODE_TERM: begin
							cmd.idx_clr = 1'b1;
							state_d     = st.empty ? S_EMIT_UNK : S_SRCH_RD;
						end
						pts_pkg::MODE_TICK: begin
							if (policy_q == pts_pkg::POL_RR && !st.empty) begin
								state_d = st.jr ? S_TICK_JR : S_TICK_STOP_RD;
							end
						end
						default: begin
							if (policy_q == pts_pkg::POL_NONE) begin
								state_d = S_IDLE;
							end else if (st.empty) begin
								state_d = S_EMIT_DONE;
							end else if (policy_q == pts_pkg::POL_RR) begin
								cmd.ptr_clr  = 1'b1;
								cmd.jr_clr   = 1'b1;
								cmd.best_clr = 1'b1;
								state_d      = S_START_RD;
							end else begin
								term_d  = 1'b0;
								state_d = S_SEL_INIT;
							end
						end
					endcase
				end
			end
			S_ADD_WR: begin
				cmd.wr_append = 1'b1;
				state_d       = S_IDLE;
			end
			S_EMIT_FULL: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_act  = pts_pkg::ACT_FULL;
					cmd.emit_ref  = pts_pkg::REF_TID;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_EMIT_UNK: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_act  = pts_pkg::ACT_UNKNOWN;
					cmd.emit_ref  = pts_pkg::REF_TID;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_EMIT_DONE: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_act  = pts_pkg::ACT_ALL_DONE;
					cmd.emit_ref  = pts_pkg::REF_ZERO;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_EMIT_TERM: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_act  = pts_pkg::ACT_TERM_OK;
					cmd.emit_ref  = pts_pkg::REF_TID;
					cmd.emit_last = follow_q == S_IDLE;
					state_d       = follow_q;
				end
			end
			S_SRCH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = pts_pkg::RD_IDX;
				state_d    = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (st.match) begin
					state_d = S_COMP;
				end else if (st.idx_last) begin
					state_d = S_EMIT_UNK;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SRCH_RD;
				end
			end
			S_COMP: begin
				if (st.idx_last) begin
					state_d = S_REMOVE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = pts_pkg::RD_IDX_P1;
					state_d    = S_COMP_WR;
				end
			end
			S_COMP_WR: begin
				cmd.wr_compact = 1'b1;
				cmd.idx_inc    = 1'b1;
				state_d        = S_COMP;
			end
			S_REMOVE: begin
				cmd.remove = 1'b1;
				if (st.count_one) begin
					follow_d = S_EMIT_DONE;
					state_d  = S_EMIT_TERM;
				end else if (policy_q == pts_pkg::POL_FCFS || policy_q == pts_pkg::POL_SJF) begin
					term_d  = 1'b1;
					state_d = S_SEL_INIT;
				end else begin
					follow_d = S_IDLE;
					state_d  = S_EMIT_TERM;
				end
			end
			S_SEL_INIT: begin
				cmd.best_clr = 1'b1;
				cmd.idx_clr  = 1'b1;
				state_d      = (policy_q == pts_pkg::POL_SJF) ? S_SCAN_RD : S_SEL_DONE;
			end
			S_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = pts_pkg::RD_IDX;
				state_d    = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_upd = 1'b1;
				if (st.idx_last) begin
					state_d = S_SEL_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_SEL_DONE: begin
				if (term_q) begin
					follow_d = st.flag_best ? S_IDLE : S_START_RD;
					state_d  = S_EMIT_TERM;
				end else begin
					state_d = st.flag_best ? S_IDLE : S_START_RD;
				end
			end
			S_START_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = pts_pkg::RD_BEST;
				state_d    = S_START_EMIT;
			end
			S_START_EMIT: begin
				if (st.out_free) begin
					cmd.emit          = 1'b1;
					cmd.emit_act      = pts_pkg::ACT_START;
					cmd.emit_ref      = pts_pkg::REF_RD;
					cmd.emit_last     = 1'b1;
					cmd.flag_set_best = 1'b1;
					state_d           = S_IDLE;
				end
			end
			S_TICK_JR: begin
				cmd.ptr_wrap = 1'b1;
				cmd.jr_clr   = 1'b1;
				state_d      = S_TICK_LOAD;
			end
			S_TICK_STOP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = pts_pkg::RD_PTR;
				state_d    = S_TICK_STOP_EM;
			end
			S_TICK_STOP_EM: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_act  = pts_pkg::ACT_STOP;
					cmd.emit_ref  = pts_pkg::REF_RD;
					cmd.emit_last = 1'b0;
					cmd.ptr_adv   = 1'b1;
					state_d       = S_TICK_LOAD;
				end
			end
			S_TICK_LOAD: begin
				cmd.best_from_ptr = 1'b1;
				state_d           = S_START_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			follow_q <= S_IDLE;
			term_q   <= 1'b0;
			policy_q <= pts_pkg::POL_NONE;
		end else begin
			state_q  <= state_d;
			follow_q <= follow_d;
			term_q   <= term_d;
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
		end
	end

endmodule

[sv/process_table_scheduler_top.sv]
// Process table scheduler: a compacting task table with round robin, FCFS and SJF start.
// Events arrive on evt and results leave on result, each a valid/ready transfer; a transfer
// happens at a rising edge of clk with valid and ready high. cfg_we writes the 2-bit policy.
// An add event stores a task and returns nothing, or one table-full result. A terminate
// event returns terminated-ok or unknown-id, possibly followed by all-done or a start. A tick
// under round robin with a non-empty table returns stop and start, or a single start after
// a removal. A begin returns one start, all-done or nothing. The final result of each event
// carries last. The controller walks the task tables one entry at a time through their
// single read port: a search, shift or scan reads an entry in one state and compares or
// writes it in a second.
// evt is ready only between events; the next event is taken while the final result still
// sits in the output register. If result is stalled the controller waits with the pending
// result held. Reset clears the table count, flags, pointer and policy; no clearing pass runs.
module process_table_scheduler_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	pts_evt_if.sink    evt,
	pts_res_if.source  result
);

	pts_pkg::cmd_t    cmd;
	pts_pkg::status_t st;

	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.evt_mode  (evt.mode),
		.st        (st),
		.cmd       (cmd)
	);

	pts_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.in_task_id       (evt.task_id),
		.in_expected_time (evt.expected_time),
		.out_valid        (result.valid),
		.out_ready        (result.ready),
		.out_action       (result.action),
		.out_task_ref     (result.task_ref),
		.out_last         (result.last)
	);

endmodule
